FILE: rtl/wwcf_pkg.sv
// ----------------------------------------------------------------------------
// wwcf_pkg
// Shared types and constants for the whole-word censor filter.
// ----------------------------------------------------------------------------
package wwcf_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int IDX_W       = $clog2(MAX_PATTERN);
   localparam int CNT_W       = $clog2(MAX_PATTERN + 2);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] STAR_BYTE  = 8'h2A;

   // register indexes, taken from paddr[4:3]
   localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
   localparam logic [1:0] REG_PATTERN_LOW    = 2'd1;
   localparam logic [1:0] REG_PATTERN_HIGH   = 2'd2;

   // one unit of output work: a token flush followed by an optional tail byte
   typedef struct packed {
      logic [CNT_W-1:0]                 flush_cnt;
      logic                             match;
      logic [MAX_PATTERN-1:0][7:0]      tokens;
      logic                             tail_valid;
      logic [7:0]                       tail_byte;
      logic                             fin;
   } job_type;

endpackage

FILE: rtl/wwcf_front.sv
// ----------------------------------------------------------------------------
// wwcf_front
// Accepts input words, holds the current token and classifies each word
// into an output job.
// ----------------------------------------------------------------------------
module wwcf_front import wwcf_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,    // byte_in
   input  logic                        req_tlast,    // is_final
   input  logic [4:0]                  pattern_length,
   input  logic [8*MAX_PATTERN-1:0]    pattern_bytes,
   input  logic                        q_full,
   output logic                        q_push,
   output job_type                     q_job
);

   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   logic [MAX_PATTERN-1:0][7:0] store_ff, store_in;
   logic [CNT_W-1:0]            held_ff, held_in;
   logic                        passing_ff, passing_in;

   logic                        accept;
   logic                        is_space;
   logic [CNT_W-1:0]            eff_len;
   logic                        do_store;
   logic [CNT_W-1:0]            flush_cnt;
   logic                        tail_valid;
   logic [MAX_PATTERN-1:0]      byte_ok;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign is_space   = (req_tdata == SPACE_BYTE);

   always_comb begin
      if (pattern_length == 5'd0) begin
         eff_len = CNT_W'(1);
      end else if (pattern_length > 5'(MAX_PATTERN)) begin
         eff_len = CNT_W'(MAX_PATTERN);
      end else begin
         eff_len = CNT_W'(pattern_length);
      end
   end

   always_comb begin
      store_in   = store_ff;
      held_in    = held_ff;
      passing_in = passing_ff;
      do_store   = 1'b0;
      flush_cnt  = '0;
      tail_valid = 1'b0;
      if (is_space) begin
         flush_cnt  = passing_ff ? '0 : held_ff;
         tail_valid = 1'b1;
         held_in    = '0;
         passing_in = 1'b0;
      end else if (passing_ff) begin
         tail_valid = 1'b1;
      end else if (held_ff < eff_len && held_ff < CNT_W'(MAX_PATTERN)) begin
         do_store = 1'b1;
         store_in[held_ff[IDX_W-1:0]] = req_tdata;
         held_in  = held_ff + CNT_W'(1);
         if (req_tlast) begin
            flush_cnt = held_ff + CNT_W'(1);
         end
      end else begin
         // token outgrew the pattern: flush what is held, pass the rest
         flush_cnt  = held_ff;
         tail_valid = 1'b1;
         passing_in = 1'b1;
         held_in    = '0;
      end
      if (req_tlast) begin
         held_in    = '0;
         passing_in = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         byte_ok[i] = (CNT_W'(i) >= flush_cnt) ||
                      (fold(store_in[i]) == fold(pattern_bytes[8*i +: 8]));
      end
   end

   always_comb begin
      q_job.flush_cnt  = flush_cnt;
      q_job.match      = (flush_cnt == eff_len) && (&byte_ok);
      q_job.tokens     = store_in;
      q_job.tail_valid = tail_valid;
      q_job.tail_byte  = req_tdata;
      q_job.fin        = req_tlast;
   end

   assign q_push = accept && (tail_valid || flush_cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         passing_ff <= 1'b0;
      end else if (accept) begin
         held_ff    <= held_in;
         passing_ff <= passing_in;
      end
   end

   // token store: no reset, only entries written for the current token are read
   always_ff @(posedge clock) begin
      if (accept && do_store) begin
         store_ff <= store_in;
      end
   end

endmodule

FILE: rtl/wwcf_queue.sv
// ----------------------------------------------------------------------------
// wwcf_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module wwcf_queue import wwcf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  job_type  push_job,
   output logic     full,
   input  logic     pop,
   output logic     q_valid,
   output job_type  q_job
);

   job_type             mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_job   = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/wwcf_back.sv
// ----------------------------------------------------------------------------
// wwcf_back
// Takes jobs from the queue and emits their bytes, one per cycle unless the
// receiver stalls, into the output register.
// ----------------------------------------------------------------------------
module wwcf_back import wwcf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  job_type     q_job,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // byte_out
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser    // message_done
);

   job_type           job_ff;
   logic              busy_ff;
   logic [CNT_W-1:0]  pos_ff;
   logic              out_valid_ff;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_done_ff;

   logic              load_ok;
   logic              step;
   logic [CNT_W-1:0]  total;

   assign load_ok = !out_valid_ff || rsp_tready;
   assign step    = busy_ff && load_ok;
   assign q_pop   = !busy_ff && q_valid;
   assign total   = job_ff.flush_cnt + CNT_W'(job_ff.tail_valid);

   always_comb begin
      if (pos_ff < job_ff.flush_cnt) begin
         out_byte_in = job_ff.match ? STAR_BYTE : job_ff.tokens[pos_ff[IDX_W-1:0]];
      end else begin
         out_byte_in = job_ff.tail_byte;
      end
      out_last_in = (pos_ff + CNT_W'(1) == total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            busy_ff <= 1'b1;
            pos_ff  <= '0;
         end else if (step) begin
            pos_ff <= pos_ff + CNT_W'(1);
            if (out_last_in) begin
               busy_ff <= 1'b0;
            end
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_job;
      end
      if (step) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
         out_done_ff <= out_last_in && job_ff.fin;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

endmodule

FILE: rtl/whole_word_censor_filter_core.sv
// ----------------------------------------------------------------------------
// whole_word_censor_filter_core
// Byte stream filter that replaces a configured whole word with asterisks.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : message bytes in, one word per byte; req_tlast marks the last
//            byte of a message and closes the token being held.
//   rsp_*  : filtered bytes out; rsp_tlast marks the last byte caused by one
//            input word, rsp_tuser the final byte of a message.
//   csr_*  : APB-style registers at 0x00 pattern_length, 0x08 pattern low
//            bytes, 0x10 pattern high bytes. Write only while idle.
// Path: a word that releases bytes is written into the queue, loaded as a
//   job into the back, and its first byte then enters the output register.
// Throughput: the front takes one word per cycle while the 2-entry job
//   queue has room. The back emits one byte per cycle while not stalled;
//   a job of k bytes (k up to 17: a held token plus its closing byte) ends
//   before the next starts; long flushes back-pressure input via the queue.
// Reset: token state, queue and output register clear; pattern length
//   returns to 1, pattern bytes to 0. No clearing pass is needed.
// Receiver stall: the output register holds its byte; the back and then the
//   queue stop, and req_tready drops once the queue is full.
// ----------------------------------------------------------------------------
module whole_word_censor_filter_core import wwcf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // input stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] byte_in
   input  logic         req_tlast,    // is_final
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,    // [7:0] byte_out
   output logic         rsp_tlast,    // last_of_run
   output logic         rsp_tuser,    // [0] message_done
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   // ---- registers ----
   logic [4:0]   pattern_length_ff;
   logic [63:0]  pattern_low_ff;
   logic [63:0]  pattern_high_ff;
   logic         csr_write;
   logic [1:0]   csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= 5'd1;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_PATTERN_LENGTH: pattern_length_ff <= csr_pwdata[4:0];
            REG_PATTERN_LOW:    pattern_low_ff    <= csr_pwdata;
            REG_PATTERN_HIGH:   pattern_high_ff   <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PATTERN_LENGTH: csr_prdata = {59'd0, pattern_length_ff};
         REG_PATTERN_LOW:    csr_prdata = pattern_low_ff;
         REG_PATTERN_HIGH:   csr_prdata = pattern_high_ff;
         default:            csr_prdata = '0;
      endcase
   end

   // ---- front: token tracking and classification ----
   logic     q_push, q_full, q_pop, q_valid;
   job_type  push_job, head_job;

   wwcf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .pattern_length (pattern_length_ff),
      .pattern_bytes  ({pattern_high_ff, pattern_low_ff}),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (push_job)
   );

   // ---- job queue ----
   wwcf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .q_valid  (q_valid),
      .q_job    (head_job)
   );

   // ---- back: byte emission ----
   wwcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // ---- checks ----
   // message end is always the last byte of its run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("message_done without last_of_run");

   // the front never pushes into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into full queue");

   // a pop only happens with a job at the queue head
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // output is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

FILE: tb/whole_word_censor_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whole_word_censor_filter_core_tb
// Self-checking bench for the whole-word censor filter. A scoreboard class
// mirrors the token logic (case-folded whole-word compare, asterisk masking,
// pass-through of long tokens and spaces) and checks every output word in
// order. Stimulus is a short directed sequence followed by random messages
// built mostly from the configured word, its case variants and near misses,
// under random idling on both streams, one long receiver hold-off and
// register changes between drained phases.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [7:0] data;
   logic       last_of_run;
   logic       message_done;
} censor_byte_type;

class censor_scoreboard;
   censor_byte_type pending[$];
   int              errors;
   logic [7:0]      token_bytes[wwcf_pkg::MAX_PATTERN];
   int              held;
   bit              passing;
   logic [4:0]      len_reg;
   logic [63:0]     pat_low;
   logic [63:0]     pat_high;
   censor_byte_type staged;
   bit              have_staged;

   function new();
      errors      = 0;
      held        = 0;
      passing     = 0;
      len_reg     = 5'd1;
      pat_low     = '0;
      pat_high    = '0;
      have_staged = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
         wwcf_pkg::REG_PATTERN_LENGTH: len_reg  = value[4:0];
         wwcf_pkg::REG_PATTERN_LOW:    pat_low  = value;
         wwcf_pkg::REG_PATTERN_HIGH:   pat_high = value;
         default: ;
      endcase
   endfunction

   function int word_len();
      int n;
      n = len_reg;
      if (n < 1) n = 1;
      if (n > wwcf_pkg::MAX_PATTERN) n = wwcf_pkg::MAX_PATTERN;
      return n;
   endfunction

   function logic [7:0] fold(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

   function logic [7:0] pattern_byte(int i);
      logic [63:0] w;
      w = (i < 8) ? pat_low : pat_high;
      return w[(i % 8) * 8 +: 8];
   endfunction

   // last result of a step is held back so its flags can be set at the end
   function void emit(logic [7:0] b);
      if (have_staged) pending.push_back(staged);
      staged      = '{data: b, last_of_run: 1'b0, message_done: 1'b0};
      have_staged = 1;
   endfunction

   function void flush_token();
      bit hit;
      hit = (held == word_len());
      for (int i = 0; i < held; i++)
         if (hit && fold(token_bytes[i]) != fold(pattern_byte(i))) hit = 0;
      for (int i = 0; i < held; i++)
         emit(hit ? wwcf_pkg::STAR_BYTE : token_bytes[i]);
      held = 0;
   endfunction

   function void note_byte(logic [7:0] b, logic fin);
      if (b == wwcf_pkg::SPACE_BYTE) begin
         if (!passing) flush_token();
         emit(b);
         held    = 0;
         passing = 0;
      end else if (passing) begin
         emit(b);
      end else if (held < word_len()) begin
         token_bytes[held] = b;
         held++;
      end else begin
         flush_token();
         emit(b);
         passing = 1;
      end
      if (fin) begin
         flush_token();
         passing = 0;
      end
      if (have_staged) begin
         staged.last_of_run  = 1'b1;
         staged.message_done = fin;
         pending.push_back(staged);
         have_staged = 0;
      end
   endfunction

   function void check_byte(logic [7:0] b, logic last, logic done);
      censor_byte_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected output byte %02h last %0b done %0b",
                  $time, b, last, done);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (want.data !== b) begin
         $display("%0t: byte_out expected %02h actual %02h", $time, want.data, b);
         errors++;
      end
      if (want.last_of_run !== last) begin
         $display("%0t: last_of_run expected %0b actual %0b",
                  $time, want.last_of_run, last);
         errors++;
      end
      if (want.message_done !== done) begin
         $display("%0t: message_done expected %0b actual %0b",
                  $time, want.message_done, done);
         errors++;
      end
   endfunction

   function int outstanding();
      return pending.size();
   endfunction
endclass

module whole_word_censor_filter_core_tb;
   import wwcf_pkg::*;

   localparam int RANDOM_ITEMS    = 120;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 8;    // back end may still be busy after a drain

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   censor_scoreboard sb;

   // stimulus-side view of the configured word, used to build matching tokens
   int          word_len_now;
   logic [7:0]  word_now[MAX_PATTERN];
   logic [7:0]  msg_q[$];
   int          items_sent = 0;
   bit          no_idle = 0;
   int          hold_off_seq = 0;
   int          hold_off_seen = 0;
   int          stall_left = 0;
   int          quiet_cycles = 0;

   whole_word_censor_filter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [7:0] byte_in
      .req_tlast   (req_tlast),    // is_final
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [7:0] byte_out
      .rsp_tlast   (rsp_tlast),    // last_of_run
      .rsp_tuser   (rsp_tuser),    // [0] message_done
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // monitors: note accepted input words, check accepted output words
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_byte(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // receiver: random idling, plus a long hold-off whenever one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_seq != hold_off_seen) begin
         hold_off_seen <= hold_off_seq;
         stall_left    <= HOLD_OFF_CYCLES;
         rsp_tready    <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= 9);
      end
   end

   // watchdog: too long without any accepted word on either stream
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("whole_word_censor_filter_core verification failed");
            $finish;
         end
      end
   end

   // one register write: setup cycle, then access cycle until pready
   task write_reg(input logic [1:0] idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task configure(input logic [4:0] len_raw, input logic [63:0] low, input logic [63:0] high);
      write_reg(REG_PATTERN_LENGTH, {59'd0, len_raw});
      write_reg(REG_PATTERN_LOW, low);
      write_reg(REG_PATTERN_HIGH, high);
      // zero acts as one, anything past the store size as the store size
      word_len_now = (len_raw == 0) ? 1 : (len_raw > MAX_PATTERN) ? MAX_PATTERN : len_raw;
      for (int i = 0; i < MAX_PATTERN; i++)
         word_now[i] = (i < 8) ? low[i * 8 +: 8] : high[(i - 8) * 8 +: 8];
   endtask

   // offer one word; valid stays up after the handshake for the next call
   task send_byte(input logic [7:0] b, input logic fin);
      if (!no_idle && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task send_text(input string s, input bit fin);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
   endtask

   // sender pauses until every expected output has arrived, then lets the
   // back end settle so a register write never lands mid-flush
   task wait_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function logic [7:0] rand_nonspace();
      logic [7:0] b;
      do b = $urandom_range(0, 255); while (b == SPACE_BYTE);
      return b;
   endfunction

   function bit is_alpha(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   // mostly letters so tokens can match; now and then a star or a space
   function logic [63:0] random_pattern();
      logic [63:0] w;
      int r;
      for (int i = 0; i < 8; i++) begin
         r = $urandom_range(0, 99);
         if (r < 80)      w[i * 8 +: 8] = $urandom_range(0, 25) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
         else if (r < 92) w[i * 8 +: 8] = rand_nonspace();
         else if (r < 97) w[i * 8 +: 8] = STAR_BYTE;
         else             w[i * 8 +: 8] = SPACE_BYTE;
      end
      return w;
   endfunction

   // token kinds: exact word in random case, word with one byte changed,
   // prefix or extension of the word, random non-space bytes
   task add_token();
      int kind, n, pos;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      pos  = $urandom_range(0, word_len_now - 1);
      if (kind < 65) begin
         for (int i = 0; i < word_len_now; i++) begin
            b = word_now[i];
            if (is_alpha(b) && $urandom_range(0, 1)) b = b ^ 8'h20;
            if (kind >= 45 && i == pos) b = rand_nonspace();
            msg_q.push_back(b);
         end
      end else begin
         n = $urandom_range(1, word_len_now + 2);
         for (int i = 0; i < n; i++)
            msg_q.push_back((kind < 80 && i < word_len_now) ? word_now[i] : rand_nonspace());
      end
   endtask

   // a message of a few tokens; most end with the final flag, the rest
   // leave a token held across the next phase
   task send_message();
      int ntok;
      bit fin;
      ntok = $urandom_range(1, 4);
      fin  = ($urandom_range(0, 4) != 0);
      msg_q.delete();
      if ($urandom_range(0, 9) == 0) msg_q.push_back(SPACE_BYTE);
      for (int t = 0; t < ntok; t++) begin
         add_token();
         if (t < ntok - 1) repeat ($urandom_range(1, 2)) msg_q.push_back(SPACE_BYTE);
      end
      if ($urandom_range(0, 9) == 0) msg_q.push_back(SPACE_BYTE);
      for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], fin && (i == msg_q.size() - 1));
   endtask

   initial begin
      int ph, start, directed;
      logic [4:0] len;
      sb = new();
      word_len_now = 1;
      for (int i = 0; i < MAX_PATTERN; i++) word_now[i] = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // reset config: one-byte word 0x00
      send_byte(8'h00, 1'b0);            // held
      send_byte(SPACE_BYTE, 1'b0);       // closes a matching token
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);            // overflow flush, then pass-through, final
      wait_results();

      // three-byte word with a star in it; case folding on letters
      configure(5'd3, 64'h0000_0000_0074_2A43, 64'hFFFF_FFFF_FFFF_FFFF);
      send_text("c*T ", 1'b0);
      send_text("CAT", 1'b1);            // final closes a non-matching token
      send_text("c*", 1'b0);             // two bytes left held
      wait_results();

      // length drops below what is held: next byte flushes unmatched
      configure(5'd1, 64'h0000_0000_0074_2A43, 64'h0);
      send_byte(8'h78, 1'b1);
      wait_results();

      // word containing a space never matches
      configure(5'd2, 64'h0000_0000_0000_2061, 64'h0);
      send_text("a a", 1'b1);
      wait_results();

      // length zero behaves as one; a lone star matches
      configure(5'd0, 64'h0000_0000_0000_002A, 64'h0);
      send_text("* *", 1'b1);
      wait_results();

      // top length value clamps to the store size
      configure(5'd31, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_byte(SPACE_BYTE, 1'b1);       // final on a space
      send_byte(8'h71, 1'b1);            // final on a lone held byte
      directed = items_sent;

      // --- random part ---
      ph = 0;
      while (items_sent < directed + RANDOM_ITEMS) begin
         wait_results();
         case (ph)
            0: len = 5'd16;
            1: len = 5'd1;
            2: len = 5'd31;
            3: len = 5'd0;
            default: begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16);
            end
         endcase
         configure(len, random_pattern(), random_pattern());
         no_idle = (ph == 2);              // one stretch without any idling
         if (ph == 0) hold_off_seq++;      // long receiver stall with 17-byte flushes queued
         start = items_sent;
         while (items_sent - start < 30) send_message();
         ph++;
      end
      no_idle = 0;

      wait_results();
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("whole_word_censor_filter_core verification clean");
      end else begin
         $display("whole_word_censor_filter_core verification failed");
      end
      $finish;
   end

endmodule
